// ----- rtl/pfc_buffer_admission_accounting_macros.svh -----
// Assertion macros used by the checker file of the PFC buffer accounting block.
// No dependencies; the including file supplies clock, reset and the expressions.
`ifndef PFC_BUFFER_ADMISSION_ACCOUNTING_MACROS_SVH
`define PFC_BUFFER_ADMISSION_ACCOUNTING_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PFCBA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfcba assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PFCBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfcba assertion failed");

`endif

// ----- rtl/pfcba_pkg.sv -----
// Package of the PFC buffer accounting block: sizes, codes and shared types.
// No dependencies; the interfaces, modules, checker and testbench of the block import it.
package pfcba_pkg;

   localparam int NUM_PORTS   = 64;
   localparam int COUNT_WIDTH = 32;
   localparam int PIDX_W      = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

   localparam int OP_W       = 2;
   localparam int PID_W      = 6;
   localparam int BYTE_W     = 20;
   localparam int BUF_W      = 32;
   localparam int SHIFT_W    = 5;
   localparam int RESERVE_W  = 20;
   localparam int MARGIN_W   = 20;
   localparam int TOT_W      = 38;
   localparam int ERR_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Width that holds any sum or difference compared against a counter or threshold.
   localparam int CMP_W   = ((COUNT_WIDTH > BUF_W) ? COUNT_WIDTH : BUF_W) + 1;
   localparam int TAKEN_W = ((TOT_W > COUNT_WIDTH) ? TOT_W : COUNT_WIDTH) + 2;

   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

   typedef logic [OP_W-1:0]      opcode_type;
   typedef logic [ERR_W-1:0]     error_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam opcode_type OP_REGISTER = OP_W'(0);
   localparam opcode_type OP_ARRIVE   = OP_W'(1);
   localparam opcode_type OP_DEPART   = OP_W'(2);
   localparam opcode_type OP_CHECK    = OP_W'(3);

   localparam error_type ERR_OK           = ERR_W'(0);
   localparam error_type ERR_UNKNOWN_PORT = ERR_W'(1);
   localparam error_type ERR_DUPLICATE    = ERR_W'(2);
   localparam error_type ERR_DEPART_BIG   = ERR_W'(3);

   localparam csr_index_type CSR_BUFFER_SIZE   = CSR_IDX_W'(0);
   localparam csr_index_type CSR_ALPHA_SHIFT   = CSR_IDX_W'(1);
   localparam csr_index_type CSR_PORT_RESERVE  = CSR_IDX_W'(2);
   localparam csr_index_type CSR_RESUME_MARGIN = CSR_IDX_W'(3);

   localparam logic [BUF_W-1:0]     BUFFER_SIZE_RST   = BUF_W'(1048576);
   localparam logic [SHIFT_W-1:0]   ALPHA_SHIFT_RST   = SHIFT_W'(3);
   localparam logic [RESERVE_W-1:0] PORT_RESERVE_RST  = '0;
   localparam logic [MARGIN_W-1:0]  RESUME_MARGIN_RST = '0;

   // One row of the per-port table.
   typedef struct packed {
      logic [COUNT_WIDTH-1:0] ingress;
      logic [COUNT_WIDTH-1:0] hr_used;
      logic [BYTE_W-1:0]      hr_limit;
      logic                   paused;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [PIDX_W-1:0] addr;
      entry_type        data;
      logic             set_valid;
   } tbl_wr_type;

   typedef struct packed {
      logic [BUF_W-1:0] free;
      logic [BUF_W-1:0] thr;
   } thr_type;

   typedef struct packed {
      logic      pause_now;
      logic      resume_now;
      logic      can_admit;
      error_type error_code;
   } result_type;

endpackage

// ----- rtl/pfcba_if.sv -----
// Valid/ready channel interfaces for the request and response sides.
// Depends on pfcba_pkg for field widths.
interface pfcba_req_if import pfcba_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [PID_W-1:0]  port_id;
   logic [BYTE_W-1:0] byte_count;

   modport source (output valid, output opcode, output port_id, output byte_count,
                   input ready);
   modport sink   (input valid, input opcode, input port_id, input byte_count,
                   output ready);
endinterface

interface pfcba_rsp_if import pfcba_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             pause_now;
   logic             resume_now;
   logic             can_admit;
   logic [ERR_W-1:0] error_code;

   modport source (output valid, output pause_now, output resume_now, output can_admit,
                   output error_code, input ready);
   modport sink   (input valid, input pause_now, input resume_now, input can_admit,
                   input error_code, output ready);
endinterface

// ----- rtl/pfc_buffer_admission_accounting.sv -----
// Top level of the PFC ingress buffer admission and accounting block.
// Depends on pfcba_pkg, pfcba_if, pfcba_thresh and pfcba_port_table.
//
//   Channel    Direction  Handshake          Payload
//   req_chan   in         valid/ready        opcode, port_id, byte_count
//   rsp_chan   out        valid/ready        pause_now, resume_now, can_admit, error_code
//   csr_*      in         csr_write_en only  csr_index, csr_wdata
//
// A register, check or rejected request gives its response from the calculation step;
// an arrive or depart passes through the wait and flag steps before its response. The
// next request is held off until the response is in the output register and the
// two-stage threshold pipeline, fed by the totals, has settled after every counter
// update or register write; the table read is registered.
// Reset is synchronous and active high; the per-port table is not cleared, its valid
// flags are. A stalled response waits in a holding register without blocking the table.

module pfc_buffer_admission_accounting import pfcba_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   pfcba_req_if.sink             req_chan,
   pfcba_rsp_if.source           rsp_chan,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CALC = 3'd1;
   localparam logic [2:0] ST_WAIT = 3'd2;
   localparam logic [2:0] ST_FLAG = 3'd3;
   localparam logic [2:0] ST_PUSH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [1:0] settle_ff, settle_in;

   // Configuration registers.
   logic [BUF_W-1:0]     buffer_size_ff;
   logic [SHIFT_W-1:0]   alpha_shift_ff;
   logic [RESERVE_W-1:0] port_reserve_ff;
   logic [MARGIN_W-1:0]  resume_margin_ff;

   // Running totals.
   logic [TOT_W-1:0]       total_headroom_ff, total_headroom_in;
   logic [TOT_W-1:0]       total_reserved_ff, total_reserved_in;
   logic [COUNT_WIDTH-1:0] pool_used_ff, pool_used_in;

   // Request held for the duration of its processing.
   opcode_type        op_ff;
   logic [PID_W-1:0]  pid_ff;
   logic [BYTE_W-1:0] bytes_ff;

   // Working row and the port's shared use after the update.
   entry_type              entry_ff, entry_in;
   logic [COUNT_WIDTH-1:0] ps_ff, ps_in;

   // Pending and presented responses.
   result_type res_ff, res_in;
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic       req_fire;
   logic       slot_free;
   tbl_wr_type tbl_wr;
   entry_type  cur;
   logic       cur_valid;
   thr_type    thr_q;

   // Datapath terms.
   logic                   in_range;
   logic [CMP_W-1:0]       arr_now, arr_over, share_add, hr_sum, sp_sum, held;
   logic                   arr_in_reserve, arr_to_headroom;
   logic [COUNT_WIDTH-1:0] ps_old, ps_new;
   logic [BYTE_W-1:0]      from_h, rest, from_s;
   logic                   dep_too_big;
   logic                   no_headroom, no_shared;
   logic [BUF_W-1:0]       thr_after;
   logic                   pause_c, resume_c;

   logic       done_c;
   result_type done_res;

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && (settle_ff == 2'd0);
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;

   pfcba_port_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_fire),
      .rd_addr  (PIDX_W'(req_chan.port_id)),
      .wr       (tbl_wr),
      .rd_data  (cur),
      .rd_valid (cur_valid)
   );

   pfcba_thresh u_thresh (
      .clock          (clock),
      .total_headroom (total_headroom_ff),
      .total_reserved (total_reserved_ff),
      .pool_used      (pool_used_ff),
      .buffer_size    (buffer_size_ff),
      .alpha_shift    (alpha_shift_ff),
      .thr_o          (thr_q)
   );

   // Configuration writes. Keep the block idle whenever one arrives; nothing checks it.
   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_size_ff   <= BUFFER_SIZE_RST;
         alpha_shift_ff   <= ALPHA_SHIFT_RST;
         port_reserve_ff  <= PORT_RESERVE_RST;
         resume_margin_ff <= RESUME_MARGIN_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_BUFFER_SIZE:   buffer_size_ff   <= BUF_W'(csr_wdata);
            CSR_ALPHA_SHIFT:   alpha_shift_ff   <= SHIFT_W'(csr_wdata);
            CSR_PORT_RESERVE:  port_reserve_ff  <= RESERVE_W'(csr_wdata);
            CSR_RESUME_MARGIN: resume_margin_ff <= MARGIN_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   // The threshold registers, free space and then threshold, must follow any change of the
   // totals or of the configuration; new requests are held off until then.
   always_comb begin
      if (csr_write_en || (state_ff == ST_CALC)) begin
         settle_in = 2'd2;
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end else begin
         settle_in = 2'd0;
      end
   end

   // Arithmetic for the calculation, shared-use and flag steps.
   always_comb begin
      in_range = 32'(pid_ff) < 32'(NUM_PORTS);

      // Shared use of the port before this request.
      if (CMP_W'(cur.ingress) > CMP_W'(port_reserve_ff)) begin
         ps_old = COUNT_WIDTH'(CMP_W'(cur.ingress) - CMP_W'(port_reserve_ff));
      end else begin
         ps_old = '0;
      end

      // Arrive: reserve first, then shared pool under the threshold, else headroom.
      arr_now         = CMP_W'(cur.ingress) + CMP_W'(bytes_ff);
      arr_in_reserve  = arr_now <= CMP_W'(port_reserve_ff);
      arr_over        = arr_now - CMP_W'(port_reserve_ff);
      arr_to_headroom = arr_over > CMP_W'(thr_q.thr);
      share_add       = (CMP_W'(bytes_ff) < arr_over) ? CMP_W'(bytes_ff) : arr_over;
      hr_sum          = CMP_W'(cur.hr_used) + CMP_W'(bytes_ff);
      sp_sum          = CMP_W'(pool_used_ff) + share_add;

      // Depart: headroom drains first, then ingress, of which part was shared.
      held        = CMP_W'(cur.ingress) + CMP_W'(cur.hr_used);
      dep_too_big = CMP_W'(bytes_ff) > held;
      from_h      = (CMP_W'(cur.hr_used) < CMP_W'(bytes_ff)) ? BYTE_W'(cur.hr_used) : bytes_ff;
      rest        = bytes_ff - from_h;
      from_s      = (CMP_W'(rest) < CMP_W'(ps_old)) ? rest : BYTE_W'(ps_old);

      // Admission check.
      no_headroom = (CMP_W'(bytes_ff) + CMP_W'(cur.hr_used)) > CMP_W'(cur.hr_limit);
      no_shared   = (CMP_W'(bytes_ff) + CMP_W'(ps_old)) > CMP_W'(thr_q.thr);

      // Shared use after the update, taken from the working row.
      if (CMP_W'(entry_ff.ingress) > CMP_W'(port_reserve_ff)) begin
         ps_new = COUNT_WIDTH'(CMP_W'(entry_ff.ingress) - CMP_W'(port_reserve_ff));
      end else begin
         ps_new = '0;
      end

      // Threshold seen after the totals changed.
      thr_after = thr_q.free >> alpha_shift_ff;
      pause_c   = !entry_ff.paused &&
                  ((entry_ff.hr_used != '0) || (CMP_W'(ps_ff) >= CMP_W'(thr_after)));
      resume_c  = entry_ff.paused && (entry_ff.hr_used == '0) &&
                  ((ps_ff == '0) ||
                   ((CMP_W'(ps_ff) + CMP_W'(resume_margin_ff)) <= CMP_W'(thr_after)));
   end

   // Sequencer and state updates.
   always_comb begin
      state_in          = state_ff;
      entry_in          = entry_ff;
      ps_in             = ps_ff;
      res_in            = res_ff;
      rsp_in            = rsp_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_chan.ready;
      total_headroom_in = total_headroom_ff;
      total_reserved_in = total_reserved_ff;
      pool_used_in      = pool_used_ff;
      tbl_wr            = '0;
      tbl_wr.addr       = PIDX_W'(pid_ff);
      done_c            = 1'b0;
      done_res          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            entry_in = cur;
            priority if (!in_range) begin
               done_c              = 1'b1;
               done_res.error_code = ERR_UNKNOWN_PORT;
            end else if (op_ff == OP_REGISTER) begin
               done_c = 1'b1;
               if (cur_valid) begin
                  done_res.error_code = ERR_DUPLICATE;
               end else begin
                  tbl_wr.en                = 1'b1;
                  tbl_wr.set_valid         = 1'b1;
                  tbl_wr.data.ingress      = '0;
                  tbl_wr.data.hr_used      = '0;
                  tbl_wr.data.hr_limit     = bytes_ff;
                  tbl_wr.data.paused       = 1'b0;
                  total_headroom_in        = total_headroom_ff + TOT_W'(bytes_ff);
                  total_reserved_in        = total_reserved_ff + TOT_W'(port_reserve_ff);
               end
            end else if (!cur_valid) begin
               done_c              = 1'b1;
               done_res.error_code = ERR_UNKNOWN_PORT;
            end else if (op_ff == OP_ARRIVE) begin
               state_in = ST_WAIT;
               priority if (arr_in_reserve) begin
                  entry_in.ingress = COUNT_WIDTH'(arr_now);
               end else if (arr_to_headroom) begin
                  entry_in.hr_used = (hr_sum > CMP_W'(CMAX)) ? CMAX : COUNT_WIDTH'(hr_sum);
               end else begin
                  entry_in.ingress = (arr_now > CMP_W'(CMAX)) ? CMAX : COUNT_WIDTH'(arr_now);
                  pool_used_in     = (sp_sum > CMP_W'(CMAX)) ? CMAX : COUNT_WIDTH'(sp_sum);
               end
            end else if (op_ff == OP_DEPART) begin
               if (dep_too_big) begin
                  done_c              = 1'b1;
                  done_res.error_code = ERR_DEPART_BIG;
               end else begin
                  state_in         = ST_WAIT;
                  entry_in.hr_used = cur.hr_used - COUNT_WIDTH'(from_h);
                  entry_in.ingress = COUNT_WIDTH'(CMP_W'(cur.ingress) - CMP_W'(rest));
                  if (CMP_W'(pool_used_ff) > CMP_W'(from_s)) begin
                     pool_used_in =
                        COUNT_WIDTH'(CMP_W'(pool_used_ff) - CMP_W'(from_s));
                  end else begin
                     pool_used_in = '0;
                  end
               end
            end else begin
               done_c             = 1'b1;
               done_res.can_admit = !(no_headroom && no_shared);
            end
         end
         ST_WAIT: begin
            ps_in    = ps_new;
            state_in = ST_FLAG;
         end
         ST_FLAG: begin
            done_c      = 1'b1;
            tbl_wr.en   = 1'b1;
            tbl_wr.data = entry_ff;
            if (op_ff == OP_ARRIVE) begin
               done_res.pause_now = pause_c;
               tbl_wr.data.paused = entry_ff.paused || pause_c;
            end else begin
               done_res.resume_now = resume_c;
               tbl_wr.data.paused  = entry_ff.paused && !resume_c;
            end
         end
         ST_PUSH: begin
            if (slot_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A finished response goes straight out if the output slot is free, else it waits.
      if (done_c) begin
         if (slot_free) begin
            rsp_in       = done_res;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end else begin
            res_in   = done_res;
            state_in = ST_PUSH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         settle_ff         <= 2'd2;
         rsp_valid_ff      <= 1'b0;
         total_headroom_ff <= '0;
         total_reserved_ff <= '0;
         pool_used_ff      <= '0;
      end else begin
         state_ff          <= state_in;
         settle_ff         <= settle_in;
         rsp_valid_ff      <= rsp_valid_in;
         total_headroom_ff <= total_headroom_in;
         total_reserved_ff <= total_reserved_in;
         pool_used_ff      <= pool_used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_chan.opcode;
         pid_ff   <= req_chan.port_id;
         bytes_ff <= req_chan.byte_count;
      end
      entry_ff <= entry_in;
      ps_ff    <= ps_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.pause_now  = rsp_ff.pause_now;
   assign rsp_chan.resume_now = rsp_ff.resume_now;
   assign rsp_chan.can_admit  = rsp_ff.can_admit;
   assign rsp_chan.error_code = rsp_ff.error_code;

endmodule

// ----- rtl/pfcba_thresh.sv -----
// Registered free-space and dynamic-threshold pipeline.
// Depends on pfcba_pkg; the free space is registered, and the threshold is registered from it.
module pfcba_thresh import pfcba_pkg::*; (
   input  logic                   clock,
   input  logic [TOT_W-1:0]       total_headroom,
   input  logic [TOT_W-1:0]       total_reserved,
   input  logic [COUNT_WIDTH-1:0] pool_used,
   input  logic [BUF_W-1:0]       buffer_size,
   input  logic [SHIFT_W-1:0]     alpha_shift,
   output thr_type                thr_o
);

   logic [TAKEN_W-1:0] taken;
   logic [BUF_W-1:0]   free_in, free_ff;
   logic [BUF_W-1:0]   thr_in, thr_ff;

   always_comb begin
      taken = TAKEN_W'(total_headroom) + TAKEN_W'(total_reserved) + TAKEN_W'(pool_used);
      if (TAKEN_W'(buffer_size) > taken) begin
         free_in = BUF_W'(TAKEN_W'(buffer_size) - taken);
      end else begin
         free_in = '0;
      end
      thr_in = free_ff >> alpha_shift;
   end

   always_ff @(posedge clock) begin
      free_ff <= free_in;
      thr_ff  <= thr_in;
   end

   assign thr_o.free = free_ff;
   assign thr_o.thr  = thr_ff;

endmodule

// ----- rtl/pfcba_port_table.sv -----
// Per-port state memory with one registered read port, one write port and valid flags.
// Depends on pfcba_pkg for the row layout and the port count.
module pfcba_port_table import pfcba_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [PIDX_W-1:0] rd_addr,
   input  tbl_wr_type        wr,
   output entry_type         rd_data,
   output logic              rd_valid
);

   entry_type              mem [NUM_PORTS];
   logic [NUM_PORTS-1:0]   valid_ff;
   entry_type              rd_data_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // Rows hold garbage until registered; the flag says whether a row is live.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en && wr.set_valid) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

// ----- rtl/pfcba_checker.sv -----
// Port-level assertions for the PFC buffer accounting block, bound to its top level.
// Depends on pfcba_pkg and the macro header.
`include "pfc_buffer_admission_accounting_macros.svh"

module pfcba_checker import pfcba_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_pause_now,
   input logic             rsp_resume_now,
   input logic             rsp_can_admit,
   input logic [ERR_W-1:0] rsp_error_code,
   input logic             csr_write_en
);

   // A response that is not taken stays offered.
   `PFCBA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // Only one request is in the table pipeline at a time.
   `PFCBA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   // A register write holds off requests until the threshold has followed it.
   `PFCBA_ASSERT_NEXT(a_csr_interlock, clock, reset, csr_write_en, !req_ready)

   // A rejected request raises no flag.
   `PFCBA_ASSERT_NOW(a_error_clean, clock, reset, rsp_valid && (rsp_error_code != ERR_OK), !rsp_pause_now && !rsp_resume_now && !rsp_can_admit)

endmodule

bind pfc_buffer_admission_accounting pfcba_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_pause_now  (rsp_chan.pause_now),
   .rsp_resume_now (rsp_chan.resume_now),
   .rsp_can_admit  (rsp_chan.can_admit),
   .rsp_error_code (rsp_chan.error_code),
   .csr_write_en   (csr_write_en)
);

// ----- tb/sv/pfc_buffer_admission_accounting_tb.sv -----
// Self-checking testbench for the PFC ingress buffer admission and accounting block.
// Depends on pfcba_pkg, the pfcba_req_if/pfcba_rsp_if interfaces and the block's top level.
// It drives requests against a cycle-free accounting model and checks every response in order.
module pfc_buffer_admission_accounting_tb import pfcba_pkg::*; ();

   // A quiet stretch as long as STALL_LIMIT can only mean that the block is stuck.
   localparam int          STALL_LIMIT   = 2000;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          END_CYCLES    = 10;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          PRINT_LIMIT   = 100;
   localparam int          FILL_ARRIVALS = 16;
   localparam int unsigned BYTE_MAX      = (1 << BYTE_W) - 1;

   typedef logic [63:0]          wide_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [TOT_W-1:0]     total_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pfcba_req_if req_if ();
   pfcba_rsp_if rsp_if ();

   pfc_buffer_admission_accounting DUT (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_if),
      .rsp_chan     (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Accounting model. It mirrors the per-port table, the buffer totals and the
   // four configuration registers, and it is advanced once per request transfer.
   // ---------------------------------------------------------------------------
   logic                   port_known   [NUM_PORTS];
   count_type              ingress_cnt  [NUM_PORTS];
   count_type              headroom_cnt [NUM_PORTS];
   logic [BYTE_W-1:0]      headroom_cap [NUM_PORTS];
   logic                   pause_state  [NUM_PORTS];
   total_type              headroom_total;
   total_type              reserve_total;
   count_type              shared_total;
   logic [BUF_W-1:0]       buffer_bytes;
   logic [SHIFT_W-1:0]     alpha;
   logic [RESERVE_W-1:0]   reserve_bytes;
   logic [MARGIN_W-1:0]    margin_bytes;
   int                     known_ports[$];

   // Responses predicted at request transfer, oldest first.
   result_type pending_results[$];

   int mismatch_count = 0;
   int response_count = 0;
   int quiet_cycles   = 0;

   // Idling controls shared by the request driver and the response ready process.
   bit req_idle_on  = 1'b1;
   bit rsp_idle_on  = 1'b1;
   int hold_request = 0;
   int stall_left   = 0;

   // Dynamic threshold: the free part of the buffer shifted right by alpha.
   function automatic wide_type free_threshold();
      wide_type taken;
      taken = wide_type'(headroom_total) + wide_type'(reserve_total) + wide_type'(shared_total);
      if (wide_type'(buffer_bytes) > taken)
         return (wide_type'(buffer_bytes) - taken) >> alpha;
      return '0;
   endfunction

   function automatic wide_type clamp_count(wide_type v);
      return (v > wide_type'(CMAX)) ? wide_type'(CMAX) : v;
   endfunction

   // A port's share of the pool is whatever it holds above its reserve.
   function automatic wide_type shared_use(int p);
      if (wide_type'(ingress_cnt[p]) > wide_type'(reserve_bytes))
         return wide_type'(ingress_cnt[p]) - wide_type'(reserve_bytes);
      return '0;
   endfunction

   // Applies one request to the model and returns the response it must produce.
   function automatic result_type account(opcode_type op, logic [PID_W-1:0] pid,
                                          logic [BYTE_W-1:0] bytes);
      result_type res;
      wide_type   b, n, thr, over, from_h, rest, from_s, used;
      logic       no_h, no_s;
      int         p;
      res = '0;
      res.error_code = ERR_OK;
      p = int'(pid);
      b = wide_type'(bytes);
      if (op == OP_REGISTER) begin
         if (port_known[p]) begin
            res.error_code = ERR_DUPLICATE;
         end else begin
            port_known[p]   = 1'b1;
            ingress_cnt[p]  = '0;
            headroom_cnt[p] = '0;
            headroom_cap[p] = bytes;
            pause_state[p]  = 1'b0;
            headroom_total  = headroom_total + total_type'(bytes);
            reserve_total   = reserve_total + total_type'(reserve_bytes);
            known_ports.push_back(p);
         end
      end else if (!port_known[p]) begin
         res.error_code = ERR_UNKNOWN_PORT;
      end else if (op == OP_ARRIVE) begin
         n   = wide_type'(ingress_cnt[p]) + b;
         thr = free_threshold();
         if (n <= wide_type'(reserve_bytes)) begin
            ingress_cnt[p] = count_type'(clamp_count(n));
         end else if (n - wide_type'(reserve_bytes) > thr) begin
            // Over the threshold the packet lands in the port's headroom.
            headroom_cnt[p] = count_type'(clamp_count(wide_type'(headroom_cnt[p]) + b));
         end else begin
            over           = n - wide_type'(reserve_bytes);
            ingress_cnt[p] = count_type'(clamp_count(n));
            shared_total   = count_type'(clamp_count(wide_type'(shared_total) +
                                                     ((b < over) ? b : over)));
         end
         if (!pause_state[p] && (headroom_cnt[p] != '0 || shared_use(p) >= free_threshold()))
         begin
            pause_state[p] = 1'b1;
            res.pause_now  = 1'b1;
         end
      end else if (op == OP_DEPART) begin
         if (b > wide_type'(ingress_cnt[p]) + wide_type'(headroom_cnt[p])) begin
            res.error_code = ERR_DEPART_BIG;
         end else begin
            // Headroom drains first, then the port's ingress count.
            from_h = (wide_type'(headroom_cnt[p]) < b) ? wide_type'(headroom_cnt[p]) : b;
            rest   = b - from_h;
            over   = shared_use(p);
            from_s = (rest < over) ? rest : over;
            headroom_cnt[p] = count_type'(wide_type'(headroom_cnt[p]) - from_h);
            ingress_cnt[p]  = count_type'(wide_type'(ingress_cnt[p]) - rest);
            if (wide_type'(shared_total) > from_s)
               shared_total = count_type'(wide_type'(shared_total) - from_s);
            else
               shared_total = '0;
            if (pause_state[p] && headroom_cnt[p] == '0) begin
               used = shared_use(p);
               if (used == '0 || used + wide_type'(margin_bytes) <= free_threshold()) begin
                  pause_state[p] = 1'b0;
                  res.resume_now = 1'b1;
               end
            end
         end
      end else begin
         thr  = free_threshold();
         no_h = (b + wide_type'(headroom_cnt[p]) > wide_type'(headroom_cap[p]));
         no_s = (b + shared_use(p) > thr);
         res.can_admit = !(no_h && no_s);
      end
      return res;
   endfunction

   task automatic init_model();
      for (int i = 0; i < NUM_PORTS; i++) begin
         port_known[i]   = 1'b0;
         ingress_cnt[i]  = '0;
         headroom_cnt[i] = '0;
         headroom_cap[i] = '0;
         pause_state[i]  = 1'b0;
      end
      headroom_total = '0;
      reserve_total  = '0;
      shared_total   = '0;
      buffer_bytes   = BUFFER_SIZE_RST;
      alpha          = ALPHA_SHIFT_RST;
      reserve_bytes  = PORT_RESERVE_RST;
      margin_bytes   = RESUME_MARGIN_RST;
   endtask

   // ---------------------------------------------------------------------------
   // Response checking. Each response transfer is compared with the oldest
   // prediction; a response with nothing predicted is an error of its own.
   // ---------------------------------------------------------------------------
   task automatic report_mismatch(string detail);
      if (mismatch_count < PRINT_LIMIT)
         $display("ERROR: response %0d at %0t: %s", response_count, $realtime, detail);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_responses
      result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = pending_results.pop_front();
            if (rsp_if.pause_now !== want.pause_now)
               report_mismatch($sformatf("pause_now %b, expected %b",
                                         rsp_if.pause_now, want.pause_now));
            if (rsp_if.resume_now !== want.resume_now)
               report_mismatch($sformatf("resume_now %b, expected %b",
                                         rsp_if.resume_now, want.resume_now));
            if (rsp_if.can_admit !== want.can_admit)
               report_mismatch($sformatf("can_admit %b, expected %b",
                                         rsp_if.can_admit, want.can_admit));
            if (rsp_if.error_code !== want.error_code)
               report_mismatch($sformatf("error_code %0d, expected %0d",
                                         rsp_if.error_code, want.error_code));
         end
         response_count++;
      end
   end

   // Mostly short idle stretches, now and then a long one.
   function automatic int idle_length();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // The response ready is lowered at random, or for a requested hold-off whose
   // length this process counts down itself.
   always @(negedge clock) begin
      if (hold_request > 0) begin
         stall_left   = hold_request;
         hold_request = 0;
      end
      if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left--;
      end else if (rsp_idle_on && $urandom_range(0, 99) < 25) begin
         rsp_if.ready <= 1'b0;
         stall_left = idle_length() - 1;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Any transfer on either channel shows progress; a long silence ends the run.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("ERROR: no transfer for %0d cycles, %0d responses outstanding",
                  STALL_LIMIT, pending_results.size());
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Request driving and configuration.
   // ---------------------------------------------------------------------------

   // Offers one request, possibly after an idle gap, and records its prediction
   // at the edge where it transfers.
   task automatic send_request(opcode_type op, int port, int unsigned bytes);
      int gap;
      gap = (req_idle_on && $urandom_range(0, 1) == 1) ? idle_length() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.opcode     <= op;
      req_if.port_id    <= PID_W'(port);
      req_if.byte_count <= BYTE_W'(bytes);
      do @(posedge clock); while (req_if.ready !== 1'b1);
      pending_results.push_back(account(op, PID_W'(port), BYTE_W'(bytes)));
   endtask

   // Stops offering requests and waits for every predicted response.
   task automatic wait_for_drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      case (idx)
         CSR_BUFFER_SIZE:   buffer_bytes  = value[BUF_W-1:0];
         CSR_ALPHA_SHIFT:   alpha         = value[SHIFT_W-1:0];
         CSR_PORT_RESERVE:  reserve_bytes = value[RESERVE_W-1:0];
         CSR_RESUME_MARGIN: margin_bytes  = value[MARGIN_W-1:0];
         default: ;
      endcase
   endtask

   // Registers change only with the block idle: all responses back and the
   // threshold pipeline given time to settle.
   task automatic apply_settings(logic [31:0] size, logic [31:0] shift,
                                 logic [31:0] reserve, logic [31:0] margin);
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_register(CSR_BUFFER_SIZE, size);
      write_register(CSR_ALPHA_SHIFT, shift);
      write_register(CSR_PORT_RESERVE, reserve);
      write_register(CSR_RESUME_MARGIN, margin);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic int pick_known_port();
      return known_ports[$urandom_range(0, known_ports.size() - 1)];
   endfunction

   // Headroom sizes stay small mostly so that the buffer keeps free space.
   function automatic int unsigned headroom_size();
      if ($urandom_range(0, 99) < 80)
         return $urandom_range(0, 4095);
      return $urandom_range(0, BYTE_MAX);
   endfunction

   function automatic int unsigned packet_size();
      if ($urandom_range(0, 99) < 80)
         return $urandom_range(64, 9216);
      return $urandom_range(0, BYTE_MAX);
   endfunction

   // Mostly legal traffic on registered ports: arrivals, departures no larger
   // than what the port holds and admission checks. The rest is registrations,
   // some of them duplicates, operations on any port with any size, and
   // departures just over what is held.
   task automatic mixed_traffic(int count);
      int          r, p;
      int unsigned bytes, cap;
      wide_type    held;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 5 || known_ports.size() == 0) begin
            send_request(OP_REGISTER, $urandom_range(0, NUM_PORTS - 1), headroom_size());
         end else if (r < 10) begin
            send_request(opcode_type'($urandom_range(1, 3)), $urandom_range(0, NUM_PORTS - 1),
                         $urandom_range(0, BYTE_MAX));
         end else begin
            p = pick_known_port();
            if (r < 50) begin
               send_request(OP_ARRIVE, p, packet_size());
            end else if (r < 85) begin
               held = wide_type'(ingress_cnt[p]) + wide_type'(headroom_cnt[p]);
               if (held > wide_type'(BYTE_MAX))
                  cap = BYTE_MAX;
               else
                  cap = held[31:0];
               if (held < wide_type'(BYTE_MAX) && $urandom_range(0, 19) == 0)
                  bytes = held[31:0] + 1;
               else if ($urandom_range(0, 1) == 1)
                  bytes = cap;
               else
                  bytes = $urandom_range(0, cap);
               send_request(OP_DEPART, p, bytes);
            end else begin
               send_request(OP_CHECK, p, packet_size());
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------------

   // Every operation other than registration is refused on a port never registered.
   task automatic test_unregistered_ports();
      send_request(OP_ARRIVE, 0, 64);
      send_request(OP_DEPART, NUM_PORTS - 1, 0);
      send_request(OP_CHECK, 0, BYTE_MAX);
      send_request(OP_ARRIVE, NUM_PORTS - 1, BYTE_MAX);
   endtask

   // Registration with the largest and the smallest headroom, then duplicates.
   task automatic test_register_ports();
      send_request(OP_REGISTER, 0, BYTE_MAX);
      send_request(OP_REGISTER, NUM_PORTS - 1, 0);
      send_request(OP_REGISTER, 0, 100);
      send_request(OP_REGISTER, NUM_PORTS - 1, 'h55555);
   endtask

   // With the reset settings the two registered headrooms leave a threshold of
   // zero, so arrivals pause at once. Departures then empty the headroom and
   // resume, and a departure above what is held is refused.
   task automatic test_pause_resume();
      send_request(OP_ARRIVE, NUM_PORTS - 1, 0);
      send_request(OP_ARRIVE, 0, BYTE_MAX);
      send_request(OP_ARRIVE, 0, 1);
      send_request(OP_CHECK, 0, 0);
      send_request(OP_CHECK, 0, BYTE_MAX);
      send_request(OP_CHECK, NUM_PORTS - 1, BYTE_MAX);
      send_request(OP_DEPART, NUM_PORTS - 1, 1);
      send_request(OP_DEPART, 0, BYTE_MAX);
      send_request(OP_DEPART, 0, 1);
      send_request(OP_DEPART, NUM_PORTS - 1, 0);
   endtask

   // Traffic is charged under the largest reserve, then the reserve is cut to
   // zero so that a departure takes more from the pool than it holds and the
   // pool count stops at zero.
   task automatic test_reserve_change();
      apply_settings(32'hFFFF_FFFF, 0, BYTE_MAX, BYTE_MAX);
      send_request(OP_REGISTER, 5, 'h2AAAA);
      send_request(OP_ARRIVE, 5, 'h80000);
      send_request(OP_ARRIVE, 5, BYTE_MAX);
      send_request(OP_CHECK, 5, BYTE_MAX);
      apply_settings(32'h0030_0000, 2, 0, 0);
      send_request(OP_DEPART, 5, BYTE_MAX);
      send_request(OP_DEPART, 5, 'h80000);
      send_request(OP_CHECK, 5, 0);
   endtask

   // A buffer of size zero sends every byte to headroom; a run of full-size
   // arrivals back to back builds up a large headroom count on one port.
   task automatic test_headroom_fill();
      apply_settings(0, 31, 0, 0);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      send_request(OP_REGISTER, 7, 0);
      repeat (FILL_ARRIVALS) send_request(OP_ARRIVE, 7, BYTE_MAX);
      send_request(OP_CHECK, 7, 0);
      send_request(OP_DEPART, 7, BYTE_MAX);
      send_request(OP_DEPART, 7, BYTE_MAX);
      send_request(OP_ARRIVE, 7, BYTE_MAX);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // The receiver holds off for a long stretch while requests keep coming, so
   // the holding register fills and the block must stall its request side.
   task automatic test_backpressure();
      apply_settings(32'd16_777_216, 4, 1024, 2048);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      send_request(OP_CHECK, pick_known_port(), 64);
      hold_request = HOLD_CYCLES;
      mixed_traffic(30);
      wait_for_drain();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // Random traffic over several settings, extremes among them, with idling
   // switched on and off on each side from phase to phase.
   task automatic test_random_phases();
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: apply_settings(32'd16_777_216, 3, 2048, 4096);
            1: apply_settings($urandom_range(4_194_304, 67_108_864), $urandom_range(0, 5),
                              $urandom_range(0, 16384), $urandom_range(0, 65536));
            2: apply_settings(32'hFFFF_FFFF, 0, 0, 0);
            3: apply_settings($urandom(), $urandom_range(0, 31), $urandom_range(0, BYTE_MAX),
                              $urandom_range(0, BYTE_MAX));
            4: apply_settings(32'd8_388_608, 31, BYTE_MAX, BYTE_MAX);
            default: apply_settings($urandom_range(2_097_152, 33_554_432), $urandom_range(1, 6),
                                    $urandom_range(0, 8192), $urandom_range(0, 32768));
         endcase
         req_idle_on = (ph % 3 != 1);
         rsp_idle_on = (ph % 2 == 0);
         mixed_traffic(170);
      end
   endtask

   initial begin
      req_if.valid      = 1'b0;
      req_if.opcode     = OP_REGISTER;
      req_if.port_id    = '0;
      req_if.byte_count = '0;
      rsp_if.ready      = 1'b0;
      csr_write_en      = 1'b0;
      csr_index         = CSR_BUFFER_SIZE;
      csr_wdata         = '0;
      init_model();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_unregistered_ports();
      test_register_ports();
      test_pause_resume();
      test_reserve_change();
      test_headroom_fill();
      test_backpressure();
      test_random_phases();

      wait_for_drain();
      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/pfcba_pkg.sv
rtl/pfcba_if.sv
rtl/pfcba_thresh.sv
rtl/pfcba_port_table.sv
rtl/pfc_buffer_admission_accounting.sv
rtl/pfcba_checker.sv
tb/sv/pfc_buffer_admission_accounting_tb.sv
